### rtl/assert_macros.svh
// Assertion macros for the checker file of the formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the active-low reset is asserted.
`define ASSERT_ON_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ASSERT_SYNC(label, prop, msg) \
    `ASSERT_ON_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

### rtl/itaf_pkg.sv
// Package with the types, constants and character function of the integer formatter.
package itaf_pkg;

    localparam logic [2:0] KIND_SDEC   = 3'd0;
    localparam logic [2:0] KIND_UDEC   = 3'd1;
    localparam logic [2:0] KIND_HEXLO  = 3'd2;
    localparam logic [2:0] KIND_HEXUP  = 3'd3;
    localparam logic [2:0] KIND_PTR    = 3'd4;

    localparam int         VALUE_W     = 64;
    localparam int         CHAR_W      = 8;
    localparam int         COUNT_W     = 5;
    localparam int         DEC_DIGITS  = 10;
    localparam int         BCD_W       = 4 * DEC_DIGITS;
    localparam int         BIN_W       = 32;

    localparam logic [4:0] NDIG_DEC    = 5'd10;
    localparam logic [4:0] NDIG_HEX32  = 5'd8;
    localparam logic [4:0] NDIG_HEX64  = 5'd16;
    localparam logic [4:0] STEP_LAST   = 5'd31;

    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_A_LO   = 8'h61;
    localparam logic [7:0] CHAR_A_UP   = 8'h41;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONVERT,
        S_SKIP,
        S_PREFIX,
        S_DIGITS
    } t_state;

    typedef struct packed {
        logic load;
        logic dabble;
        logic skip;
        logic emit_pre;
        logic emit_dig;
    } t_ctrl_cmd;

    typedef struct packed {
        logic kind_ok;
        logic in_dec;
        logic last_step;
        logic lead_zero;
        logic has_prefix;
        logic pre_last;
        logic last_digit;
        logic out_free;
    } t_dp_status;

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_A_UP : CHAR_A_LO;
        if (nib < 4'd10) begin
            digit_char = CHAR_ZERO + {4'h0, nib};
        end else begin
            digit_char = base + {4'h0, nib - 4'd10};
        end
    endfunction

endpackage

### rtl/itaf_if.sv
// Valid/ready channel interfaces for the formatter's input items and output characters.
interface itaf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface itaf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic [4:0] count;
    logic       last;

    modport source (output valid, output character, output count, output last, input ready);
    modport sink   (input valid, input character, input count, input last, output ready);
endinterface

### rtl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter.
// Each accepted item is turned into its decimal or hex text, one character per output
// transfer, most significant digit first, with a running count and a last flag.
// The input is ready only while no item is in progress; kinds 5 to 7 are accepted and
// produce no output, and the block stays ready. A decimal item is loaded, passed through
// the shift-and-add-3 BCD converter over its 32 bits and then walked over its ten digit
// positions: leading zeros are stripped (the last position is always kept), then a minus
// sign is sent when negative, then the remaining digits. A 32-bit hex item is loaded and
// walked over its eight digit positions in the same way; a pointer has sixteen positions
// and two prefix characters. A character that waits in the output register with ready
// low holds up the sequence; the final character waiting there does not hold up the next
// input transfer.
module integer_to_ascii_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itaf_in_if.sink     i_in_ch,
    itaf_out_if.source  o_out_ch
);

    itaf_pkg::t_ctrl_cmd  cmd;
    itaf_pkg::t_dp_status status;
    logic                 in_ready;

    assign i_in_ch.ready = in_ready;

    itaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    itaf_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_kind   (i_in_ch.kind),
        .i_value  (i_in_ch.value),
        .i_cmd    (cmd),
        .o_status (status),
        .o_out    (o_out_ch)
    );

endmodule

### rtl/itaf_ctrl.sv
// Controller state machine that sequences load, conversion, zero skipping and character output.
module itaf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  itaf_pkg::t_dp_status  i_status,
    output logic                  o_in_ready,
    output itaf_pkg::t_ctrl_cmd   o_cmd
);

    itaf_pkg::t_state r_state;
    itaf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itaf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itaf_pkg::S_IDLE: begin
                if (i_in_valid && i_status.kind_ok) begin
                    n_state = i_status.in_dec ? itaf_pkg::S_CONVERT : itaf_pkg::S_SKIP;
                end
            end
            itaf_pkg::S_CONVERT: begin
                if (i_status.last_step) begin
                    n_state = itaf_pkg::S_SKIP;
                end
            end
            itaf_pkg::S_SKIP: begin
                if (!i_status.lead_zero) begin
                    n_state = i_status.has_prefix ? itaf_pkg::S_PREFIX : itaf_pkg::S_DIGITS;
                end
            end
            itaf_pkg::S_PREFIX: begin
                if (i_status.out_free && i_status.pre_last) begin
                    n_state = itaf_pkg::S_DIGITS;
                end
            end
            itaf_pkg::S_DIGITS: begin
                if (i_status.out_free && i_status.last_digit) begin
                    n_state = itaf_pkg::S_IDLE;
                end
            end
            default: n_state = itaf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            itaf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && i_status.kind_ok;
            end
            itaf_pkg::S_CONVERT: o_cmd.dabble   = 1'b1;
            itaf_pkg::S_SKIP:    o_cmd.skip     = i_status.lead_zero;
            itaf_pkg::S_PREFIX:  o_cmd.emit_pre = i_status.out_free;
            itaf_pkg::S_DIGITS:  o_cmd.emit_dig = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

### rtl/itaf_dpath.sv
// Datapath with the binary-to-BCD shifter, digit register, prefix logic and output register.
module itaf_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [2:0]            i_kind,
    input  logic [63:0]           i_value,
    input  itaf_pkg::t_ctrl_cmd   i_cmd,
    output itaf_pkg::t_dp_status  o_status,
    itaf_out_if.source            o_out
);

    logic [63:0] r_digits;
    logic [63:0] n_digits;
    logic [31:0] r_bin;
    logic [31:0] n_bin;
    logic [4:0]  r_ndig;
    logic [4:0]  n_ndig;
    logic [4:0]  r_step;
    logic [4:0]  n_step;
    logic [1:0]  r_npre;
    logic [1:0]  n_npre;
    logic        r_ptr;
    logic        n_ptr;
    logic        r_upper;
    logic        n_upper;
    logic [4:0]  r_count;
    logic [4:0]  n_count;

    logic        r_out_valid;
    logic        n_out_valid;
    logic [7:0]  r_char;
    logic [7:0]  n_char;
    logic [4:0]  r_cnt;
    logic [4:0]  n_cnt;
    logic        r_last;
    logic        n_last;

    logic [31:0]                low;
    logic [31:0]                mag;
    logic [itaf_pkg::BCD_W-1:0] bcd_adj;
    logic [7:0]                 pre_char;

    assign low = i_value[31:0];
    assign mag = (i_kind == itaf_pkg::KIND_SDEC && low[31]) ? (~low + 32'd1) : low;

    always_comb begin
        for (int i = 0; i < itaf_pkg::DEC_DIGITS; i++) begin
            if (r_digits[63 - 4*i -: 4] >= 4'd5) begin
                bcd_adj[itaf_pkg::BCD_W - 1 - 4*i -: 4] = r_digits[63 - 4*i -: 4] + 4'd3;
            end else begin
                bcd_adj[itaf_pkg::BCD_W - 1 - 4*i -: 4] = r_digits[63 - 4*i -: 4];
            end
        end
    end

    assign pre_char = r_ptr ? ((r_npre == 2'd2) ? itaf_pkg::CHAR_ZERO : itaf_pkg::CHAR_X)
                            : itaf_pkg::CHAR_MINUS;

    always_comb begin
        o_status.kind_ok    = (i_kind <= itaf_pkg::KIND_PTR);
        o_status.in_dec     = (i_kind == itaf_pkg::KIND_SDEC) || (i_kind == itaf_pkg::KIND_UDEC);
        o_status.last_step  = (r_step == itaf_pkg::STEP_LAST);
        o_status.lead_zero  = (r_digits[63:60] == 4'h0) && (r_ndig != 5'd1);
        o_status.has_prefix = (r_npre != 2'd0);
        o_status.pre_last   = (r_npre == 2'd1);
        o_status.last_digit = (r_ndig == 5'd1);
        o_status.out_free   = !r_out_valid || o_out.ready;
    end

    always_comb begin
        n_digits    = r_digits;
        n_bin       = r_bin;
        n_ndig      = r_ndig;
        n_step      = r_step;
        n_npre      = r_npre;
        n_ptr       = r_ptr;
        n_upper     = r_upper;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_out.ready;
        n_char      = r_char;
        n_cnt       = r_cnt;
        n_last      = r_last;

        if (i_cmd.load) begin
            n_step  = '0;
            n_count = '0;
            n_ptr   = (i_kind == itaf_pkg::KIND_PTR);
            n_upper = (i_kind == itaf_pkg::KIND_HEXUP);
            n_bin   = mag;
            case (i_kind) inside
                itaf_pkg::KIND_SDEC, itaf_pkg::KIND_UDEC: begin
                    n_digits = '0;
                    n_ndig   = itaf_pkg::NDIG_DEC;
                    n_npre   = (i_kind == itaf_pkg::KIND_SDEC && low[31]) ? 2'd1 : 2'd0;
                end
                itaf_pkg::KIND_PTR: begin
                    n_digits = i_value;
                    n_ndig   = itaf_pkg::NDIG_HEX64;
                    n_npre   = 2'd2;
                end
                default: begin
                    n_digits = {low, 32'h0};
                    n_ndig   = itaf_pkg::NDIG_HEX32;
                    n_npre   = 2'd0;
                end
            endcase
        end

        if (i_cmd.dabble) begin
            n_digits = {bcd_adj[itaf_pkg::BCD_W-2:0], r_bin[31], {(64 - itaf_pkg::BCD_W){1'b0}}};
            n_bin    = {r_bin[30:0], 1'b0};
            n_step   = r_step + 5'd1;
        end

        if (i_cmd.skip) begin
            n_digits = {r_digits[59:0], 4'h0};
            n_ndig   = r_ndig - 5'd1;
        end

        if (i_cmd.emit_pre) begin
            n_npre      = r_npre - 2'd1;
            n_count     = r_count + 5'd1;
            n_out_valid = 1'b1;
            n_char      = pre_char;
            n_cnt       = r_count + 5'd1;
            n_last      = 1'b0;
        end

        if (i_cmd.emit_dig) begin
            n_digits    = {r_digits[59:0], 4'h0};
            n_ndig      = r_ndig - 5'd1;
            n_count     = r_count + 5'd1;
            n_out_valid = 1'b1;
            n_char      = itaf_pkg::digit_char(r_digits[63:60], r_upper);
            n_cnt       = r_count + 5'd1;
            n_last      = (r_ndig == 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_bin    <= n_bin;
        r_ndig   <= n_ndig;
        r_step   <= n_step;
        r_npre   <= n_npre;
        r_ptr    <= n_ptr;
        r_upper  <= n_upper;
        r_count  <= n_count;
        r_char   <= n_char;
        r_cnt    <= n_cnt;
        r_last   <= n_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.count     = r_cnt;
    assign o_out.last      = r_last;

endmodule

### rtl/itaf_checker.sv
// Port-level assertion checker for the formatter and its bind to the top level.
`include "assert_macros.svh"

module itaf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_character,
    input logic [4:0] i_out_count,
    input logic       i_out_last
);

    logic        stall;
    logic [13:0] word;
    logic        count_ok;
    logic        full;
    logic        tail;
    logic        is_digit;

    assign stall    = i_out_valid && !i_out_ready;
    assign word     = {i_out_character, i_out_count, i_out_last};
    assign count_ok = (i_out_count >= 5'd1) && (i_out_count <= 5'd18);
    assign full     = i_out_valid && (i_out_count == 5'd18);
    assign tail     = i_out_valid && i_out_last;
    assign is_digit = ((i_out_character >= 8'h30) && (i_out_character <= 8'h39))
                   || ((i_out_character >= 8'h61) && (i_out_character <= 8'h66))
                   || ((i_out_character >= 8'h41) && (i_out_character <= 8'h46));

    `ASSERT_SYNC(a_out_hold, stall |=> i_out_valid && $stable(word), "Stalled output changed.")

    `ASSERT_SYNC(a_count_range, i_out_valid |-> count_ok, "Output count out of range.")

    `ASSERT_SYNC(a_full_is_last, full |-> i_out_last, "Eighteenth character not marked last.")

    `ASSERT_SYNC(a_last_is_digit, tail |-> is_digit, "Final character is not a digit.")

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out_ch.valid),
    .i_out_ready     (o_out_ch.ready),
    .i_out_character (o_out_ch.character),
    .i_out_count     (o_out_ch.count),
    .i_out_last      (o_out_ch.last)
);

### dv/tb_itaf_checker.sv
// Checker that predicts the formatter's text for each input transfer and compares the output.
`timescale 1ns / 1ps
module tb_itaf_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    itaf_in_if   i_in_ch,
    itaf_out_if  i_out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_items,
    output int   o_chars
);

    typedef struct packed {
        logic [7:0] character;
        logic [4:0] count;
        logic       last;
    } t_char_rec;

    t_char_rec expected_chars[$];
    int        mismatch_count    = 0;
    int        chars_outstanding = 0;
    int        items_seen        = 0;
    int        chars_seen        = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = chars_outstanding;
    assign o_items      = items_seen;
    assign o_chars      = chars_seen;

    function automatic void predict_text(input logic [2:0] kind, input logic [63:0] value);
        logic [7:0]  text[$];
        logic [7:0]  digits[$];
        logic [63:0] mag;
        logic [63:0] radix;
        logic [3:0]  nib;
        string       alphabet;
        t_char_rec   rec;
        radix    = 64'd10;
        alphabet = "0123456789abcdef";
        case (kind)
            itaf_pkg::KIND_SDEC: begin
                if (value[31]) begin
                    text.push_back(itaf_pkg::CHAR_MINUS);
                    mag = {32'd0, ~value[31:0] + 32'd1};
                end else begin
                    mag = {32'd0, value[31:0]};
                end
            end
            itaf_pkg::KIND_UDEC: begin
                mag = {32'd0, value[31:0]};
            end
            itaf_pkg::KIND_HEXLO: begin
                mag   = {32'd0, value[31:0]};
                radix = 64'd16;
            end
            itaf_pkg::KIND_HEXUP: begin
                mag      = {32'd0, value[31:0]};
                radix    = 64'd16;
                alphabet = "0123456789ABCDEF";
            end
            itaf_pkg::KIND_PTR: begin
                text.push_back(itaf_pkg::CHAR_ZERO);
                text.push_back(itaf_pkg::CHAR_X);
                mag   = value;
                radix = 64'd16;
            end
            default: begin
                return;
            end
        endcase
        do begin
            nib = 4'(mag % radix);
            digits.push_front(alphabet[nib]);
            mag = mag / radix;
        end while (mag != 64'd0);
        foreach (digits[i]) text.push_back(digits[i]);
        for (int k = 0; k < text.size(); k++) begin
            rec.character = text[k];
            rec.count     = 5'(k + 1);
            rec.last      = (k == text.size() - 1);
            expected_chars.push_back(rec);
        end
    endfunction

    task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_char_rec want;
        if (!i_rst_n) begin
            expected_chars.delete();
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                predict_text(i_in_ch.kind, i_in_ch.value);
                items_seen++;
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected transfer, expected nothing, got character %0h",
                             $time, i_out_ch.character);
                end else begin
                    want = expected_chars.pop_front();
                    check_field("character", want.character, i_out_ch.character);
                    check_field("count", 8'(want.count), 8'(i_out_ch.count));
                    check_field("last", 8'(want.last), 8'(i_out_ch.last));
                end
            end
        end
        chars_outstanding = expected_chars.size();
    end

endmodule

### dv/tb_integer_to_ascii_formatter.sv
// Testbench top that drives the formatter's channels and reports the verdict of the run.
`timescale 1ns / 1ps
module tb_integer_to_ascii_formatter;

    localparam int         HOLD_OFF_CYCLES = 200;
    localparam int         RANDOM_ITEMS    = 100;
    localparam int         SETTLE_CYCLES   = 80;
    localparam longint     RUN_LIMIT_NS    = 5_000_000;
    localparam logic [2:0] KIND_RSVD5      = 3'd5;
    localparam logic [2:0] KIND_RSVD6      = 3'd6;
    localparam logic [2:0] KIND_RSVD7      = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
    } t_item;

    localparam t_item DIRECTED [24] = '{
        '{itaf_pkg::KIND_SDEC,  64'h0000_0000_0000_0000},
        '{itaf_pkg::KIND_SDEC,  64'h0000_0000_0000_0001},
        '{itaf_pkg::KIND_SDEC,  64'h0000_0000_7FFF_FFFF},
        '{itaf_pkg::KIND_SDEC,  64'h0000_0000_8000_0000},
        '{itaf_pkg::KIND_SDEC,  64'h0000_0000_FFFF_FFFF},
        '{itaf_pkg::KIND_SDEC,  64'hFFFF_FFFF_0000_002A},
        '{itaf_pkg::KIND_UDEC,  64'h0000_0000_0000_0000},
        '{itaf_pkg::KIND_UDEC,  64'h0000_0000_FFFF_FFFF},
        '{itaf_pkg::KIND_UDEC,  64'h0000_0000_3B9A_CA00},
        '{itaf_pkg::KIND_UDEC,  64'hABCD_0000_0000_0007},
        '{itaf_pkg::KIND_HEXLO, 64'h0000_0000_0000_0000},
        '{itaf_pkg::KIND_HEXLO, 64'h0000_0000_FFFF_FFFF},
        '{itaf_pkg::KIND_HEXLO, 64'h1234_5678_DEAD_BEEF},
        '{itaf_pkg::KIND_HEXUP, 64'h0000_0000_0000_000F},
        '{itaf_pkg::KIND_HEXUP, 64'h0000_0000_FFFF_FFFF},
        '{itaf_pkg::KIND_HEXUP, 64'hFFFF_FFFF_0ABC_DEF0},
        '{itaf_pkg::KIND_PTR,   64'h0000_0000_0000_0000},
        '{itaf_pkg::KIND_PTR,   64'h0000_0000_0000_0001},
        '{itaf_pkg::KIND_PTR,   64'hFFFF_FFFF_FFFF_FFFF},
        '{itaf_pkg::KIND_PTR,   64'h8000_0000_0000_0000},
        '{itaf_pkg::KIND_PTR,   64'h0000_0001_0000_0000},
        '{KIND_RSVD5,           64'hFFFF_FFFF_FFFF_FFFF},
        '{KIND_RSVD6,           64'h0000_0000_0000_0000},
        '{KIND_RSVD7,           64'h5555_AAAA_5555_AAAA}
    };

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   items_seen;
    int   chars_seen;
    int   text_free_items = 0;
    bit   hold_off_req    = 1'b0;
    bit   hold_off_done   = 1'b0;
    bit   drain_stalls    = 1'b1;

    itaf_in_if  in_ch();
    itaf_out_if out_ch();

    integer_to_ascii_formatter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    tb_itaf_checker text_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_items      (items_seen),
        .o_chars      (chars_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [2:0] random_kind();
        if ($urandom_range(0, 19) < 18) begin
            return 3'($urandom_range(0, 4));
        end
        return 3'($urandom_range(5, 7));
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: v = v >> $urandom_range(0, 63);
            1: v = 64'($urandom_range(0, 20));
            2: begin
                p = 64'd1;
                repeat ($urandom_range(0, 9)) p = p * 64'd10;
                v = {v[63:32], 32'(p - 64'($urandom_range(0, 1)))};
            end
            3: v[31] = 1'b1;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [2:0] kind, input logic [63:0] value);
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.value <= value;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (kind > itaf_pkg::KIND_PTR) text_free_items++;
    endtask

    task automatic pause_sender(input int unsigned cycles);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic drain(input int settle);
        pause_sender(1);
        while (pending != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    initial begin : result_ready
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_off_done = 1'b1;
            end else if (drain_stalls && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap_len() - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        in_ch.valid = 1'b0;
        in_ch.kind  = itaf_pkg::KIND_SDEC;
        in_ch.value = 64'd0;
        i_rst_n     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[n]) begin
            send_item(DIRECTED[n].kind, DIRECTED[n].value);
            if ($urandom_range(0, 1) == 1) pause_sender(gap_len());
        end
        drain(SETTLE_CYCLES);

        // The sender keeps offering while the output is held off, so the block backs up.
        hold_off_req = 1'b1;
        repeat (6) send_item(random_kind(), random_value());

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            drain_stalls = !(k >= 40 && k < 60);
            send_item(random_kind(), random_value());
            if (drain_stalls && $urandom_range(0, 1) == 1) pause_sender(gap_len());
        end
        drain(SETTLE_CYCLES);

        $display("summary: %0d items formatted (%0d of an undefined kind), %0d characters checked",
                 items_seen, text_free_items, chars_seen);
        $display("summary: field extremes, a %0d-cycle output hold-off and a stall-free stretch",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/itaf_pkg.sv
rtl/itaf_if.sv
rtl/itaf_ctrl.sv
rtl/itaf_dpath.sv
rtl/integer_to_ascii_formatter.sv
rtl/itaf_checker.sv
dv/tb_itaf_checker.sv
dv/tb_integer_to_ascii_formatter.sv
